// ===== rtl/core/usb_config_descriptor_endpoint_finder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the endpoint finder unit.
// ----------------------------------------------------------------------------
`ifndef USB_CONFIG_DESCRIPTOR_ENDPOINT_FINDER_UNIT_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_ENDPOINT_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UCDEF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ucdef: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UCDEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ucdef: next-cycle check failed");

`endif

// ===== rtl/core/ucdef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucdef_pkg
// Types and constants of the configuration descriptor endpoint finder.
// ----------------------------------------------------------------------------
package ucdef_pkg;

	// One input beat: a byte of the descriptor transfer.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_last;
		logic       transfer_failed;
	} in_beat_t;

	// One result beat, produced for the last byte of a transfer.
	typedef struct packed {
		logic [2:0] result_status;
		logic [7:0] in_ep_address;
		logic [7:0] out_ep_address;
		logic       interface_found;
		logic [7:0] interface_number;
		logic [1:0] walk_stop;
	} out_beat_t;

	// Descriptor codes.
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0] XFER_TYPE_MASK = 8'h03;
	localparam logic [7:0] XFER_BULK      = 8'h02;
	localparam logic [7:0] DIR_IN_BIT     = 8'h80;

	// Register reset: vendor specific class.
	localparam logic [7:0] WANTED_CLASS_RESET = 8'hFF;

	// Result status codes.
	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_XFER_FAILED = 3'd1;
	localparam logic [2:0] STATUS_TOO_SHORT   = 3'd2;
	localparam logic [2:0] STATUS_BAD_TOTAL   = 3'd3;
	localparam logic [2:0] STATUS_NO_ENDPOINT = 3'd4;

	// Walk stop codes.
	localparam logic [1:0] STOP_NONE      = 2'd0;
	localparam logic [1:0] STOP_SHORT_LEN = 2'd1;
	localparam logic [1:0] STOP_CUT       = 2'd2;
	localparam logic [1:0] STOP_PAST_TOTAL = 2'd3;

	// Smallest transfer that holds a configuration descriptor header.
	localparam int unsigned MIN_CONFIG_BYTES = 9;

endpackage

// ===== rtl/core/ucdef_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucdef_walker
// Holds the descriptor walk state, folds in one byte per step and forms the
// result for the last byte of a transfer.
// ----------------------------------------------------------------------------
module ucdef_walker
	import ucdef_pkg::*;
#(
	parameter int unsigned MAX_CONFIG_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_beat_t   beat,
	input  logic [7:0] wanted_class,
	output out_beat_t  result
);

	localparam int unsigned CW = $clog2(MAX_CONFIG_BYTES + 1);
	localparam int unsigned RW = ((CW > 8) ? CW : 8) + 1;
	localparam int unsigned SW = ((CW > 16) ? CW : 16) + 1;

	logic [CW-1:0] byte_count_q, desc_start_q;
	logic [15:0]   total_length_q;
	logic [7:0]    desc_length_q, desc_type_q, field_a_q, field_b_q;
	logic          in_chosen_q, chosen_valid_q;
	logic [7:0]    chosen_number_q, found_in_q, found_out_q;
	logic [1:0]    stop_q;

	logic [CW-1:0] byte_count_n, desc_start_n;
	logic [15:0]   total_length_n;
	logic [7:0]    desc_length_n, desc_type_n, field_a_n, field_b_n;
	logic          in_chosen_n, chosen_valid_n;
	logic [7:0]    chosen_number_n, found_in_n, found_out_n;
	logic [1:0]    stop_n;

	logic [CW-1:0] idx, rel;
	logic [7:0]    b;
	logic          take;
	logic [1:0]    stop_rep;
	logic [2:0]    status;

	assign idx  = byte_count_q;
	assign b    = beat.data_byte;
	assign take = byte_count_q < CW'(MAX_CONFIG_BYTES);
	assign rel  = idx - desc_start_q;

	// Fold one byte into the walk state.
	always_comb begin
		byte_count_n    = byte_count_q;
		desc_start_n    = desc_start_q;
		total_length_n  = total_length_q;
		desc_length_n   = desc_length_q;
		desc_type_n     = desc_type_q;
		field_a_n       = field_a_q;
		field_b_n       = field_b_q;
		in_chosen_n     = in_chosen_q;
		chosen_valid_n  = chosen_valid_q;
		chosen_number_n = chosen_number_q;
		found_in_n      = found_in_q;
		found_out_n     = found_out_q;
		stop_n          = stop_q;
		if (take) begin
			byte_count_n = idx + CW'(1);
			// wTotalLength sits in bytes two and three, low byte first.
			if (idx == CW'(2)) begin
				total_length_n = {8'h00, b};
			end
			if (idx == CW'(3)) begin
				total_length_n = {b, total_length_q[7:0]};
				// A first descriptor that already ended gets its bound check now.
				if (stop_q == STOP_NONE &&
				    (desc_start_q == CW'(2) || desc_start_q == CW'(3)) &&
				    SW'(total_length_n) < SW'(desc_start_q)) begin
					stop_n = STOP_PAST_TOTAL;
				end
			end
			if (stop_n == STOP_NONE && idx >= desc_start_q) begin
				if (rel == CW'(0)) begin
					desc_length_n = b;
				end else if (rel == CW'(1) && desc_length_q < 8'd2) begin
					desc_type_n = b;
					stop_n      = STOP_SHORT_LEN;
				end else begin
					if (rel == CW'(1)) begin
						desc_type_n = b;
					end else if (rel == CW'(2)) begin
						field_a_n = b;
					end else if ((rel == CW'(3) && desc_type_q == TYPE_ENDPOINT) ||
					             (rel == CW'(5) && desc_type_q == TYPE_INTERFACE)) begin
						field_b_n = b;
					end
					// Last byte of the descriptor: check the bound, then apply it.
					if (RW'(rel) + RW'(1) == RW'(desc_length_q)) begin
						if (idx >= CW'(3) &&
						    SW'(desc_start_q) + SW'(desc_length_q) > SW'(total_length_n)) begin
							stop_n = STOP_PAST_TOTAL;
						end else begin
							desc_start_n = desc_start_q + CW'(desc_length_q);
							if (desc_type_n == TYPE_INTERFACE && desc_length_q >= 8'd6) begin
								in_chosen_n = (field_b_n == wanted_class);
								if (field_b_n == wanted_class) begin
									chosen_valid_n  = 1'b1;
									chosen_number_n = field_a_n;
								end
							end else if (desc_type_n == TYPE_ENDPOINT &&
							             desc_length_q >= 8'd4 && in_chosen_q) begin
								if ((field_b_n & XFER_TYPE_MASK) == XFER_BULK) begin
									if ((field_a_n & DIR_IN_BIT) != 8'h00) begin
										if (found_in_q == 8'h00) begin
											found_in_n = field_a_n;
										end
									end else if (found_out_q == 8'h00) begin
										found_out_n = field_a_n;
									end
								end
							end
						end
					end
				end
			end
		end
	end

	// Result for the last byte, from the state after this byte.
	always_comb begin
		stop_rep = stop_n;
		if (stop_n == STOP_NONE && SW'(byte_count_n) >= SW'(desc_start_n) + SW'(2)) begin
			stop_rep = STOP_CUT;
		end
		if (beat.transfer_failed) begin
			status = STATUS_XFER_FAILED;
		end else if (byte_count_n < CW'(MIN_CONFIG_BYTES)) begin
			status = STATUS_TOO_SHORT;
		end else if (total_length_n == 16'h0000 ||
		             SW'(total_length_n) > SW'(byte_count_n)) begin
			status = STATUS_BAD_TOTAL;
		end else if (found_in_n != 8'h00 && found_out_n != 8'h00) begin
			status = STATUS_OK;
		end else begin
			status = STATUS_NO_ENDPOINT;
		end
		result = '0;
		result.result_status = status;
		if (status == STATUS_OK || status == STATUS_NO_ENDPOINT) begin
			result.in_ep_address    = found_in_n;
			result.out_ep_address   = found_out_n;
			result.interface_found  = chosen_valid_n;
			result.interface_number = chosen_number_n;
			result.walk_stop        = stop_rep;
		end
	end

	// Walk state; the last byte of a transfer clears it for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			desc_start_q    <= '0;
			total_length_q  <= '0;
			desc_length_q   <= '0;
			desc_type_q     <= '0;
			field_a_q       <= '0;
			field_b_q       <= '0;
			in_chosen_q     <= 1'b1;
			chosen_valid_q  <= 1'b0;
			chosen_number_q <= '0;
			found_in_q      <= '0;
			found_out_q     <= '0;
			stop_q          <= STOP_NONE;
		end else if (step) begin
			if (beat.byte_last) begin
				byte_count_q    <= '0;
				desc_start_q    <= '0;
				total_length_q  <= '0;
				desc_length_q   <= '0;
				desc_type_q     <= '0;
				field_a_q       <= '0;
				field_b_q       <= '0;
				in_chosen_q     <= 1'b1;
				chosen_valid_q  <= 1'b0;
				chosen_number_q <= '0;
				found_in_q      <= '0;
				found_out_q     <= '0;
				stop_q          <= STOP_NONE;
			end else begin
				byte_count_q    <= byte_count_n;
				desc_start_q    <= desc_start_n;
				total_length_q  <= total_length_n;
				desc_length_q   <= desc_length_n;
				desc_type_q     <= desc_type_n;
				field_a_q       <= field_a_n;
				field_b_q       <= field_b_n;
				in_chosen_q     <= in_chosen_n;
				chosen_valid_q  <= chosen_valid_n;
				chosen_number_q <= chosen_number_n;
				found_in_q      <= found_in_n;
				found_out_q     <= found_out_n;
				stop_q          <= stop_n;
			end
		end
	end

endmodule

// ===== rtl/core/usb_config_descriptor_endpoint_finder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_finder_unit
// Walks a USB configuration descriptor byte by byte and reports the first
// bulk IN and OUT endpoints in wanted-class interfaces or before any interface.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one descriptor byte per beat, with byte_last on
// the final byte and transfer_failed sampled on that byte. The output channel
// carries one result beat per transfer, for its last byte; other bytes give
// no result. Both channels use valid and stall. A byte enters an input
// register on acceptance and is folded into the walk state as it leaves
// that register. One byte per cycle is taken while in_stall is low; the
// walk update between the input and result registers is combinational.
// While a result waits under stall, further bytes of the next transfer are
// still taken; only a second last byte holds in the input register, and
// then in_stall rises. Bytes past MAX_CONFIG_BYTES are dropped. Reset
// clears the walk, empties both registers and sets the wanted class to
// 0xFF. The user must write wanted_class through cfg_wr_en only while the
// block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_finder_unit
	import ucdef_pkg::*;
#(
	parameter int unsigned MAX_CONFIG_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_beat_t   in_beat,
	output logic       out_valid,
	input  logic       out_stall,
	output out_beat_t  out_beat
);

	`include "usb_config_descriptor_endpoint_finder_unit_macros.svh"

	logic [7:0] wanted_class_q;
	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       adv_s1;
	logic       out_valid_q;
	out_beat_t  out_beat_q;
	out_beat_t  result;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_class_q <= WANTED_CLASS_RESET;
		end else if (cfg_wr_en) begin
			wanted_class_q <= cfg_wr_data;
		end
	end

	// A byte leaves the input register unless it is a last byte and the
	// result register still holds an untaken beat.
	assign adv_s1   = valid_s1 && !(beat_s1.byte_last && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_beat;
		end
	end

	ucdef_walker #(
		.MAX_CONFIG_BYTES(MAX_CONFIG_BYTES)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.beat        (beat_s1),
		.wanted_class(wanted_class_q),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && beat_s1.byte_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && beat_s1.byte_last) begin
			out_beat_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	// Input stalls only behind a held result.
	`UCDEF_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	// An early status hides the walk.
	`UCDEF_ASSERT_NOW(a_early_status_clean, clk, arst_n,
		out_valid && (out_beat.result_status == STATUS_XFER_FAILED ||
		out_beat.result_status == STATUS_TOO_SHORT ||
		out_beat.result_status == STATUS_BAD_TOTAL),
		out_beat.in_ep_address == 8'h00 && out_beat.out_ep_address == 8'h00 &&
		!out_beat.interface_found && out_beat.interface_number == 8'h00 &&
		out_beat.walk_stop == STOP_NONE)
	// An ok status means both endpoints were found.
	`UCDEF_ASSERT_NOW(a_ok_has_endpoints, clk, arst_n,
		out_valid && out_beat.result_status == STATUS_OK,
		out_beat.in_ep_address != 8'h00 && out_beat.out_ep_address != 8'h00)
	// No interface number without a matching interface.
	`UCDEF_ASSERT_NOW(a_number_needs_match, clk, arst_n,
		out_valid && !out_beat.interface_found, out_beat.interface_number == 8'h00)
	// A last byte that moves on always leaves a result behind.
	`UCDEF_ASSERT_NEXT(a_last_gives_result, clk, arst_n,
		valid_s1 && beat_s1.byte_last && adv_s1, out_valid)

endmodule

// ===== tb/usb_config_descriptor_endpoint_finder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_finder_unit_tb
// Sends configuration descriptor transfers into the endpoint finder one byte
// per beat. A model of the descriptor walk, kept in this bench, predicts the
// result beat of each transfer. Every result beat is checked field by field
// against the oldest prediction. Directed transfers cover the status codes,
// the walk stop reasons and the boundary cases. Random phases then run
// well-formed descriptor sets with mutations, plus noise, at several settings
// of the wanted class; all but one phase add input gaps and output stalls.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_finder_unit_tb;
	import ucdef_pkg::*;

	localparam int unsigned MAX_BYTES     = 256;
	localparam int unsigned HALF_PERIOD   = 2;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam logic [7:0] TYPE_CONFIG         = 8'h02;
	localparam logic [7:0] TYPE_CLASS_SPECIFIC = 8'h24;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	in_beat_t   in_beat;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_beat_t  out_beat;

	// Walk state of the model, at the widths of the block.
	logic [7:0]  wanted_class;
	logic [8:0]  rx_count;
	logic [15:0] total_len;
	logic [8:0]  hdr_start;
	logic [7:0]  hdr_len;
	logic [7:0]  hdr_type;
	logic [7:0]  field_a;
	logic [7:0]  field_b;
	logic        in_wanted_if;
	logic        iface_seen;
	logic [7:0]  iface_num;
	logic [7:0]  first_in_ep;
	logic [7:0]  first_out_ep;
	logic [1:0]  walk_halt;

	out_beat_t   expected_reports[$];
	logic [7:0]  xfer[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;

	usb_config_descriptor_endpoint_finder_unit #(
		.MAX_CONFIG_BYTES(MAX_BYTES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("usb_config_descriptor_endpoint_finder_unit_tb NOT OK");
			$finish;
		end
	end

	// The result side stalls at random, except in calm stretches.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 34);
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Model of the descriptor walk
	// ------------------------------------------------------------------

	// Clears everything a transfer leaves behind; the wanted class stays.
	function automatic void restart_walk();
		rx_count     = '0;
		total_len    = '0;
		hdr_start    = '0;
		hdr_len      = '0;
		hdr_type     = '0;
		field_a      = '0;
		field_b      = '0;
		in_wanted_if = 1'b1;
		iface_seen   = 1'b0;
		iface_num    = '0;
		first_in_ep  = '0;
		first_out_ep = '0;
		walk_halt    = STOP_NONE;
	endfunction

	// A finished descriptor updates the interface choice or the endpoints.
	function automatic void settle_descriptor();
		if (hdr_type == TYPE_INTERFACE && hdr_len >= 6) begin
			in_wanted_if = (field_b == wanted_class);
			if (in_wanted_if) begin
				iface_seen = 1'b1;
				iface_num  = field_a;
			end
		end else if (hdr_type == TYPE_ENDPOINT && hdr_len >= 4 && in_wanted_if) begin
			if ((field_b & XFER_TYPE_MASK) == XFER_BULK) begin
				if ((field_a & DIR_IN_BIT) != 0) begin
					if (first_in_ep == 0)
						first_in_ep = field_a;
				end else if (first_out_ep == 0) begin
					first_out_ep = field_a;
				end
			end
		end
	endfunction

	// Folds one byte, at position rx_count, into the walk.
	function automatic void fold_byte(input logic [7:0] b);
		logic [8:0] idx;
		logic [8:0] rel;
		idx = rx_count;
		if (idx == 2)
			total_len = {8'h00, b};
		if (idx == 3) begin
			total_len[15:8] = b;
			// A first descriptor that ended before the total was known.
			if (walk_halt == STOP_NONE && (hdr_start == 2 || hdr_start == 3) &&
				total_len < hdr_start)
				walk_halt = STOP_PAST_TOTAL;
		end
		if (walk_halt != STOP_NONE || idx < hdr_start)
			return;
		rel = idx - hdr_start;
		if (rel == 0) begin
			hdr_len = b;
			return;
		end
		if (rel == 1) begin
			hdr_type = b;
			if (hdr_len < 2) begin
				walk_halt = STOP_SHORT_LEN;
				return;
			end
		end else if (rel == 2) begin
			field_a = b;
		end else if ((rel == 3 && hdr_type == TYPE_ENDPOINT) ||
			(rel == 5 && hdr_type == TYPE_INTERFACE)) begin
			field_b = b;
		end
		if (rel + 1 == hdr_len) begin
			if (idx >= 3 && hdr_start + hdr_len > total_len) begin
				walk_halt = STOP_PAST_TOTAL;
				return;
			end
			settle_descriptor();
			hdr_start = hdr_start + hdr_len;
		end
	endfunction

	// Takes one accepted beat; returns 1 with the result when it is a last byte.
	function automatic bit predict_report(input in_beat_t beat, output out_beat_t rep);
		logic [1:0] halt;
		logic [2:0] status;
		rep = '0;
		if (rx_count < MAX_BYTES) begin
			fold_byte(beat.data_byte);
			rx_count = rx_count + 1'b1;
		end
		if (!beat.byte_last)
			return 1'b0;
		halt = walk_halt;
		if (halt == STOP_NONE && rx_count >= hdr_start + 9'd2)
			halt = STOP_CUT;
		if (beat.transfer_failed)
			status = STATUS_XFER_FAILED;
		else if (rx_count < MIN_CONFIG_BYTES)
			status = STATUS_TOO_SHORT;
		else if (total_len == 0 || total_len > rx_count)
			status = STATUS_BAD_TOTAL;
		else if (first_in_ep != 0 && first_out_ep != 0)
			status = STATUS_OK;
		else
			status = STATUS_NO_ENDPOINT;
		rep.result_status = status;
		// The walk is only reported once the transfer itself is sound.
		if (status == STATUS_OK || status == STATUS_NO_ENDPOINT) begin
			rep.in_ep_address    = first_in_ep;
			rep.out_ep_address   = first_out_ep;
			rep.interface_found  = iface_seen;
			rep.interface_number = iface_num;
			rep.walk_stop        = halt;
		end
		restart_walk();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, status %0d",
					out_beat.result_status));
			end else begin
				want = expected_reports.pop_front();
				if (out_beat.result_status !== want.result_status)
					report_mismatch($sformatf("result_status got %0d want %0d",
						out_beat.result_status, want.result_status));
				if (out_beat.in_ep_address !== want.in_ep_address)
					report_mismatch($sformatf("in_ep_address got %h want %h",
						out_beat.in_ep_address, want.in_ep_address));
				if (out_beat.out_ep_address !== want.out_ep_address)
					report_mismatch($sformatf("out_ep_address got %h want %h",
						out_beat.out_ep_address, want.out_ep_address));
				if (out_beat.interface_found !== want.interface_found)
					report_mismatch($sformatf("interface_found got %b want %b",
						out_beat.interface_found, want.interface_found));
				if (out_beat.interface_number !== want.interface_number)
					report_mismatch($sformatf("interface_number got %h want %h",
						out_beat.interface_number, want.interface_number));
				if (out_beat.walk_stop !== want.walk_stop)
					report_mismatch($sformatf("walk_stop got %0d want %0d",
						out_beat.walk_stop, want.walk_stop));
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Sends one byte beat; called and returning at a falling edge.
	task automatic send_beat(input logic [7:0] b, input logic last, input logic failed);
		in_beat_t  beat;
		out_beat_t rep;
		beat.data_byte       = b;
		beat.byte_last       = last;
		beat.transfer_failed = failed;
		// Random gap, with junk on the payload while valid is low.
		if (!calm && $urandom_range(99) < 34) begin
			in_valid = 1'b0;
			in_beat  = {8'($urandom), 1'($urandom), 1'($urandom)};
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_beat  = beat;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (predict_report(beat, rep))
			expected_reports.push_back(rep);
		@(negedge clk);
	endtask

	// Sends the bytes held in xfer as one transfer.
	task automatic send_transfer(input logic failed);
		int unsigned n;
		n = xfer.size();
		for (int unsigned i = 0; i < n; i++) begin
			if (i == n - 1)
				send_beat(xfer[i], 1'b1, failed);
			else
				send_beat(xfer[i], 1'b0, 1'($urandom));
		end
	endtask

	// Waits for every expected result, then for the block to settle.
	task automatic wait_idle();
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_wanted_class(input logic [7:0] cls);
		in_valid = 1'b0;
		wait_idle();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = cls;
		@(negedge clk);
		cfg_wr_en    = 1'b0;
		wanted_class = cls;
	endtask

	// ------------------------------------------------------------------
	// Transfer building
	// ------------------------------------------------------------------

	// Configuration descriptor header; the total length is patched later.
	function automatic void start_config();
		xfer.delete();
		xfer.push_back(8'd9);
		xfer.push_back(TYPE_CONFIG);
		xfer.push_back(8'h00);
		xfer.push_back(8'h00);
		repeat (5) xfer.push_back(8'($urandom));
	endfunction

	// One descriptor; fa and fb land where the walk captures its fields.
	function automatic void add_descriptor(input logic [7:0] len, input logic [7:0] dtype,
		input logic [7:0] fa, input logic [7:0] fb);
		int unsigned n;
		n = (len < 2) ? 2 : len;
		for (int unsigned rel = 0; rel < n; rel++) begin
			if (rel == 0)
				xfer.push_back(len);
			else if (rel == 1)
				xfer.push_back(dtype);
			else if (rel == 2)
				xfer.push_back(fa);
			else if ((rel == 3 && dtype == TYPE_ENDPOINT) ||
				(rel == 5 && dtype == TYPE_INTERFACE))
				xfer.push_back(fb);
			else
				xfer.push_back(8'($urandom));
		end
	endfunction

	function automatic void add_interface(input logic [7:0] num, input logic [7:0] cls);
		add_descriptor(8'd9, TYPE_INTERFACE, num, cls);
	endfunction

	function automatic void add_endpoint(input logic [7:0] addr, input logic [7:0] attr);
		add_descriptor(8'd7, TYPE_ENDPOINT, addr, attr);
	endfunction

	function automatic void set_total(input int unsigned total);
		xfer[2] = total[7:0];
		xfer[3] = total[15:8];
	endfunction

	// Endpoint attributes, bulk most of the time.
	function automatic logic [7:0] pick_ep_attr();
		if ($urandom_range(9) < 7)
			return {6'($urandom), 2'b10};
		return 8'($urandom);
	endfunction

	// A random but well-formed descriptor set, total length left open.
	function automatic void build_random_config();
		start_config();
		if ($urandom_range(3) == 0)
			add_endpoint(8'($urandom), pick_ep_attr());
		repeat ($urandom_range(1, 3)) begin
			add_descriptor(($urandom_range(7) != 0) ? 8'd9 : 8'(5 + $urandom_range(1)),
				TYPE_INTERFACE, 8'($urandom_range(7)),
				$urandom_range(1) ? wanted_class : 8'($urandom));
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(9))
					0: add_descriptor(8'($urandom_range(3, 8)), TYPE_CLASS_SPECIFIC,
						8'($urandom), 8'($urandom));
					1: add_descriptor(8'($urandom_range(3, 4)), TYPE_ENDPOINT,
						8'($urandom), pick_ep_attr());
					default: add_endpoint(8'($urandom), pick_ep_attr());
				endcase
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Plain descriptor sets with and without an interface of the wanted class.
	task automatic test_interface_choice();
		start_config();
		add_interface(8'd0, wanted_class);
		add_endpoint(8'h81, XFER_BULK);
		add_endpoint(8'h02, XFER_BULK);
		set_total(xfer.size());
		send_transfer(1'b0);

		start_config();
		add_interface(8'd1, ~wanted_class);
		add_endpoint(8'h83, XFER_BULK);
		add_endpoint(8'h04, XFER_BULK);
		set_total(xfer.size());
		send_transfer(1'b0);

		// Endpoints ahead of any interface count; later duplicates do not.
		start_config();
		add_endpoint(8'h82, XFER_BULK);
		add_interface(8'hFF, wanted_class);
		add_endpoint(8'h01, 8'h03);
		add_endpoint(8'h86, XFER_BULK);
		add_endpoint(8'h7F, 8'hFE);
		set_total(xfer.size());
		send_transfer(1'b0);
	endtask

	// Failed, short and badly sized transfers report no walk.
	task automatic test_early_status();
		xfer = {8'h09};
		send_transfer(1'b0);
		start_config();
		xfer.pop_back();
		set_total(8);
		send_transfer(1'b0);
		start_config();
		set_total(9);
		send_transfer(1'b1);
		start_config();
		set_total(0);
		send_transfer(1'b0);
		start_config();
		set_total(16'hFFFF);
		send_transfer(1'b0);
	endtask

	// Each reason for the walk to stop, and a transfer ending on a length byte.
	task automatic test_walk_stops();
		// Length byte below two.
		start_config();
		add_interface(8'd2, wanted_class);
		add_descriptor(8'd1, TYPE_CLASS_SPECIFIC, 8'h00, 8'h00);
		add_endpoint(8'h81, XFER_BULK);
		set_total(xfer.size());
		send_transfer(1'b0);

		// Descriptor running past the total length.
		start_config();
		add_endpoint(8'h81, XFER_BULK);
		add_endpoint(8'h02, XFER_BULK);
		set_total(xfer.size() - 3);
		send_transfer(1'b0);

		// Transfer ending inside a descriptor.
		start_config();
		add_endpoint(8'h85, XFER_BULK);
		add_endpoint(8'h06, XFER_BULK);
		xfer.pop_back();
		xfer.pop_back();
		set_total(xfer.size());
		send_transfer(1'b0);

		// Transfer ending one byte into a header.
		start_config();
		add_endpoint(8'h81, XFER_BULK);
		add_endpoint(8'h02, XFER_BULK);
		xfer.push_back(8'd7);
		set_total(xfer.size());
		send_transfer(1'b0);

		// Tiny first descriptor, checked once the total is known.
		for (int unsigned low = 1; low <= 12; low += 11) begin
			xfer = {8'd2, TYPE_CONFIG, 8'(low), 8'h00};
			repeat (8) xfer.push_back(8'($urandom));
			send_transfer(1'b0);
		end
	endtask

	// Interface and endpoint descriptors too short, or just long enough, to hold their fields.
	task automatic test_short_descriptors();
		start_config();
		add_descriptor(8'd5, TYPE_INTERFACE, 8'd3, ~wanted_class);
		add_descriptor(8'd3, TYPE_ENDPOINT, 8'h81, XFER_BULK);
		add_descriptor(8'd4, TYPE_ENDPOINT, 8'h82, XFER_BULK);
		add_descriptor(8'd6, TYPE_INTERFACE, 8'd4, ~wanted_class);
		add_endpoint(8'h03, XFER_BULK);
		add_descriptor(8'd6, TYPE_INTERFACE, 8'd9, wanted_class);
		add_endpoint(8'h04, XFER_BULK);
		set_total(xfer.size());
		send_transfer(1'b0);
	endtask

	// Bytes beyond the largest transfer are dropped.
	task automatic test_overlong_transfer();
		for (int unsigned total = MAX_BYTES; total <= MAX_BYTES + 1; total++) begin
			start_config();
			add_interface(8'd5, wanted_class);
			add_endpoint(8'h81, XFER_BULK);
			add_endpoint(8'h01, XFER_BULK);
			while (xfer.size() < 300)
				add_descriptor(8'd8, TYPE_CLASS_SPECIFIC, 8'($urandom), 8'($urandom));
			set_total(total);
			send_transfer(1'b0);
		end
	endtask

	// Random transfers at one wanted class: mostly well formed, some broken,
	// some noise.
	task automatic test_random_transfers(input logic [7:0] cls, input bit quiet,
		input int unsigned budget);
		int unsigned stop_at;
		logic        failed;
		set_wanted_class(cls);
		calm    = quiet;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			failed = 1'b0;
			if ($urandom_range(99) < 15) begin
				xfer.delete();
				repeat ($urandom_range(1, 24)) xfer.push_back(8'($urandom));
				failed = 1'($urandom);
			end else begin
				build_random_config();
				case ($urandom_range(11))
					0: set_total(xfer.size() - $urandom_range(1, 8));
					1: set_total(xfer.size() + $urandom_range(1, 8));
					2: begin
						repeat ($urandom_range(1, 6)) xfer.pop_back();
						set_total(xfer.size());
					end
					3: begin
						add_descriptor(8'($urandom_range(1)), 8'($urandom), 8'h00, 8'h00);
						add_endpoint(8'($urandom), pick_ep_attr());
						set_total(xfer.size());
					end
					4: begin
						set_total(xfer.size());
						repeat ($urandom_range(1, 10)) xfer.push_back(8'($urandom));
					end
					5: begin
						set_total(xfer.size());
						failed = 1'b1;
					end
					default: set_total(xfer.size());
				endcase
			end
			send_transfer(failed);
			// Now and then the sender holds off until all results are in.
			if ($urandom_range(7) == 0) begin
				in_valid = 1'b0;
				wait_idle();
			end
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid    = 1'b0;
		in_beat     = '0;
		wanted_class = WANTED_CLASS_RESET;
		restart_walk();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_interface_choice();
		test_early_status();
		test_walk_stops();
		test_short_descriptors();
		test_overlong_transfer();
		test_random_transfers(WANTED_CLASS_RESET, 1'b0, 220);
		test_random_transfers(8'h00, 1'b1, 130);
		test_random_transfers(8'h00, 1'b0, 160);
		test_random_transfers(8'($urandom), 1'b0, 160);
		test_random_transfers(WANTED_CLASS_RESET, 1'b0, 160);

		in_valid = 1'b0;
		wait_idle();
		if (mismatches == 0)
			$display("usb_config_descriptor_endpoint_finder_unit_tb OK");
		else
			$display("usb_config_descriptor_endpoint_finder_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ucdef_pkg.sv
rtl/core/ucdef_walker.sv
rtl/core/usb_config_descriptor_endpoint_finder_unit.sv
tb/usb_config_descriptor_endpoint_finder_unit_tb.sv
